// ----- hw/rtl/slcu_pkg.sv -----
// Shared types, constants and elaboration-time helpers for the cell update core.
// No dependencies; imported by smoothlife_cell_update_core and its testbench.
`default_nettype none

package slcu_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_LOW       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_HIGH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_STEEPNESS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_STEEPNESS = 3'd5;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;

    localparam logic [4:0] SIG_LAST = 5'd16;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_WALK,
        S_DRAIN,
        S_DIVM,
        S_DIVM_W,
        S_DIVN,
        S_DIVN_W,
        S_SIG,
        S_SIG_W,
        S_SIG_MUL,
        S_SIG_FIN,
        S_BLO_A,
        S_BLO_B,
        S_BHI_A,
        S_BHI_B,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        SIG_T,
        SIG_P,
        SIG_Q
    } sig_sel_t;

    // Logistic samples at half steps, Q0.16.
    function automatic logic [15:0] sig_tab(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

    // Only ever called with constant arguments, so it folds away at elaboration.
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bit_v;
        rem   = v;
        res   = 0;
        bit_v = 64'h1 << 62;
        while (bit_v > rem)
        begin
            bit_v = bit_v >> 2;
        end
        while (bit_v != 0)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Antialiased edge weight for the k-th squared distance inside the band of radius r.
    function automatic logic [16:0] band_weight(input int r, input int k);
        longint unsigned d2;
        longint unsigned rfx;
        longint unsigned top;
        d2  = longint'(r * r - r + 1 + k);
        rfx = isqrt64(d2 << 32);
        top = longint'((2 * r + 1) * 32768);
        return 17'(top - rfx);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/smoothlife_cell_update_core.sv -----
// SmoothLife cell update core: toroidal grid store, disk kernel walk and logistic transition.
// Depends on slcu_pkg and slcu_div.
//
//   channel | direction | handshake              | word
//   in      | sink      | in_valid / in_ready    | action, col, row, cell_value
//   out     | source    | out_valid / out_ready  | new_value, out_col, out_row
//   cfg     | sink      | cfg_we (no wait)       | cfg_index, cfg_data
//
// A write word brings col and row into the grid with one subtraction per cycle, then
// writes the grid. A compute word walks the (2*OUTER_RADIUS+1)^2 kernel box at one grid
// read per cycle, then runs five divisions through the one shared divider, whose
// quotient is NW = 33 + clog2(KERNEL_CAPACITY) bits wide, then the table and multiply
// steps.
// in_ready is high only while the sequencer is idle. A result waits in the output
// register; the next compute word stalls only if it finishes while that result is untaken.
// Reset idles the sequencer and loads the default configuration; the grid store holds no reset value.
`default_nettype none

module smoothlife_cell_update_core #(
    parameter int GRID_WIDTH      = 256,
    parameter int GRID_HEIGHT     = 256,
    parameter int OUTER_RADIUS    = 21,
    parameter int INNER_RADIUS    = 7,
    parameter int KERNEL_CAPACITY = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [7:0]                     col,
    input  wire logic [7:0]                     row,
    input  wire logic [16:0]                    cell_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [16:0]                         new_value,
    output logic [7:0]                          out_col,
    output logic [7:0]                          out_row,
    input  wire logic                           cfg_we,
    input  wire logic [slcu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slcu_pkg::CFG_DATA_W-1:0] cfg_data
);

    import slcu_pkg::*;

    localparam int CW   = $clog2(GRID_WIDTH);
    localparam int HW   = $clog2(GRID_HEIGHT);
    localparam int CXW  = (CW > 8) ? CW : 8;
    localparam int RXW  = (HW > 8) ? HW : 8;
    localparam int XW   = CW + 2;
    localparam int YW   = HW + 2;
    localparam int AW   = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int BOX  = 2 * OUTER_RADIUS;
    localparam int DCW  = $clog2(BOX + 1);
    localparam int RW   = $clog2(OUTER_RADIUS + 1);
    localparam int RMAX = (INNER_RADIUS > OUTER_RADIUS) ? INNER_RADIUS : OUTER_RADIUS;
    localparam int D2W  = $clog2(2 * RMAX * RMAX + RMAX + 1);
    localparam int BNI  = 2 * INNER_RADIUS;
    localparam int BNO  = 2 * OUTER_RADIUS;
    localparam int BIW  = (BNI > 1) ? $clog2(BNI) : 1;
    localparam int BOW  = $clog2(BNO);
    localparam int KCW  = $clog2(KERNEL_CAPACITY + 1);
    localparam int SW   = 33 + $clog2(KERNEL_CAPACITY);
    localparam int TW   = 17 + $clog2(KERNEL_CAPACITY);
    localparam int NW   = SW;

    // Kernel band tables, filled from constant functions.
    logic [16:0] band_i [BNI];
    logic [16:0] band_o [BNO];

    for (genvar k = 0; k < BNI; k++)
    begin : g_band_i
        assign band_i[k] = band_weight(INNER_RADIUS, k);
    end
    for (genvar k = 0; k < BNO; k++)
    begin : g_band_o
        assign band_o[k] = band_weight(OUTER_RADIUS, k);
    end

    logic [16:0] cell_mem [DEPTH];

    state_t       state_reg, state_next;
    sig_sel_t     sel_reg, sel_next;
    logic         act_reg, act_next;
    logic [7:0]   col_reg, col_next;
    logic [7:0]   row_reg, row_next;
    logic [CXW-1:0] c_reg, c_next;
    logic [RXW-1:0] r_reg, r_next;
    logic [16:0]  val_reg, val_next;
    logic [DCW-1:0] dx_reg, dx_next;
    logic [DCW-1:0] dy_reg, dy_next;
    logic [KCW-1:0] kcnt_reg, kcnt_next;
    logic [TW-1:0]  tot_m_reg, tot_m_next;
    logic [TW-1:0]  tot_n_reg, tot_n_next;
    logic [SW-1:0]  sum_m_reg, sum_m_next;
    logic [SW-1:0]  sum_n_reg, sum_n_next;
    logic [16:0]  wm_s_reg, wm_s_next;
    logic [16:0]  wn_s_reg, wn_s_next;
    logic         keep_s_reg, keep_s_next;
    logic [16:0]  rd_data_reg;
    logic [16:0]  m_reg, m_next;
    logic [16:0]  n_reg, n_next;
    logic [16:0]  t_reg, t_next;
    logic [16:0]  p_reg, p_next;
    logic [16:0]  q_reg, q_next;
    logic [15:0]  lo_reg, lo_next;
    logic [15:0]  hi_reg, hi_next;
    logic [33:0]  macc_reg, macc_next;
    logic         out_valid_reg, out_valid_next;
    logic [16:0]  new_value_reg, new_value_next;
    logic [7:0]   out_col_reg, out_col_next;
    logic [7:0]   out_row_reg, out_row_next;

    logic [15:0]  birth_low_reg, birth_high_reg, death_low_reg, death_high_reg;
    logic [15:0]  ring_reg, inner_reg;

    // Kernel walk, first stage.
    logic [RW-1:0]  adx, ady;
    logic [D2W-1:0] d2, d2_off_i, d2_off_o;
    logic [16:0]    wi, wo, wn;
    logic           keep_a;
    logic [XW-1:0]  tx, xw;
    logic [YW-1:0]  ty, yw;
    logic [CW-1:0]  x;
    logic [HW-1:0]  y;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [16:0]    wr_data;
    logic           mem_we;
    logic [33:0]    pm, pn;

    // Transition datapath.
    logic [16:0]  sx, sa;
    logic [15:0]  sw_raw, sw_eff;
    logic         slt;
    logic [16:0]  sd;
    logic         div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [TW-1:0] div_den;
    logic         sat;
    logic [3:0]   idx;
    logic [14:0]  frac;
    logic [15:0]  tab_lo, tab_hi;
    logic [16:0]  sig_v, sig_res;
    logic [16:0]  fill;
    logic [16:0]  ma, mb;
    logic [33:0]  mp, blend_sum;

    always_comb
    begin
        adx = (dx_reg >= DCW'(OUTER_RADIUS)) ? RW'(dx_reg - DCW'(OUTER_RADIUS))
                                             : RW'(DCW'(OUTER_RADIUS) - dx_reg);
        ady = (dy_reg >= DCW'(OUTER_RADIUS)) ? RW'(dy_reg - DCW'(OUTER_RADIUS))
                                             : RW'(DCW'(OUTER_RADIUS) - dy_reg);
        d2  = D2W'(D2W'(adx) * D2W'(adx)) + D2W'(D2W'(ady) * D2W'(ady));
        d2_off_i = d2 - D2W'(INNER_RADIUS * INNER_RADIUS - INNER_RADIUS + 1);
        d2_off_o = d2 - D2W'(OUTER_RADIUS * OUTER_RADIUS - OUTER_RADIUS + 1);
        if (d2 <= D2W'(INNER_RADIUS * INNER_RADIUS - INNER_RADIUS))
            wi = ONE_Q16;
        else if (d2 <= D2W'(INNER_RADIUS * INNER_RADIUS + INNER_RADIUS))
            wi = band_i[d2_off_i[BIW-1:0]];
        else
            wi = '0;
        if (d2 <= D2W'(OUTER_RADIUS * OUTER_RADIUS - OUTER_RADIUS))
            wo = ONE_Q16;
        else if (d2 <= D2W'(OUTER_RADIUS * OUTER_RADIUS + OUTER_RADIUS))
            wo = band_o[d2_off_o[BOW-1:0]];
        else
            wo = '0;
        wn     = (wo > wi) ? wo - wi : '0;
        keep_a = ((wi != '0) || (wn != '0)) && (kcnt_reg < KCW'(KERNEL_CAPACITY));

        // Toroidal wrap of the offset coordinates.
        tx = XW'(c_reg[CW-1:0]) + XW'(dx_reg);
        if (tx < XW'(OUTER_RADIUS))
            xw = tx + XW'(GRID_WIDTH - OUTER_RADIUS);
        else if (tx >= XW'(GRID_WIDTH + OUTER_RADIUS))
            xw = tx - XW'(GRID_WIDTH + OUTER_RADIUS);
        else
            xw = tx - XW'(OUTER_RADIUS);
        ty = YW'(r_reg[HW-1:0]) + YW'(dy_reg);
        if (ty < YW'(OUTER_RADIUS))
            yw = ty + YW'(GRID_HEIGHT - OUTER_RADIUS);
        else if (ty >= YW'(GRID_HEIGHT + OUTER_RADIUS))
            yw = ty - YW'(GRID_HEIGHT + OUTER_RADIUS);
        else
            yw = ty - YW'(OUTER_RADIUS);
        x = xw[CW-1:0];
        y = yw[HW-1:0];
        rd_addr = AW'(AW'(y) * AW'(GRID_WIDTH)) + AW'(x);
        wr_addr = AW'(AW'(r_reg[HW-1:0]) * AW'(GRID_WIDTH)) + AW'(c_reg[CW-1:0]);
        wr_data = (val_reg > ONE_Q16) ? ONE_Q16 : val_reg;
    end

    assign pm = 34'(rd_data_reg) * 34'(wm_s_reg);
    assign pn = 34'(rd_data_reg) * 34'(wn_s_reg);

    always_comb
    begin
        case (sel_reg)
            SIG_T:
            begin
                sx     = m_reg;
                sa     = HALF_Q16;
                sw_raw = inner_reg;
            end
            SIG_P:
            begin
                sx     = n_reg;
                sa     = {1'b0, lo_reg};
                sw_raw = ring_reg;
            end
            default:
            begin
                sx     = n_reg;
                sa     = {1'b0, hi_reg};
                sw_raw = ring_reg;
            end
        endcase
        sw_eff = (sw_raw == '0) ? 16'd1 : sw_raw;
        slt    = sx < sa;
        sd     = slt ? sa - sx : sx - sa;

        case (state_reg)
            S_DIVM:
            begin
                div_num = sum_m_reg;
                div_den = tot_m_reg;
            end
            S_DIVN:
            begin
                div_num = sum_n_reg;
                div_den = tot_n_reg;
            end
            default:
            begin
                div_num = NW'({sd, 18'b0});
                div_den = TW'(sw_eff);
            end
        endcase
        div_start = (state_reg == S_DIVM) || (state_reg == S_DIVN) || (state_reg == S_SIG);

        fill   = (div_quo > NW'(ONE_Q16)) ? ONE_Q16 : div_quo[16:0];
        sat    = |div_quo[NW-1:19];
        idx    = div_quo[18:15];
        frac   = div_quo[14:0];
        tab_lo = sig_tab({1'b0, idx});
        tab_hi = sig_tab({1'b0, idx} + 5'd1);
        sig_v  = sat ? {1'b0, sig_tab(SIG_LAST)}
                     : {1'b0, tab_lo} + 17'(macc_reg >> 15);
        sig_res = slt ? ONE_Q16 - sig_v : sig_v;

        // One multiplier serves interpolation, both blends and the final product.
        case (state_reg)
            S_SIG_MUL:
            begin
                ma = {1'b0, tab_hi - tab_lo};
                mb = {2'b0, frac};
            end
            S_BLO_A:
            begin
                ma = {1'b0, birth_low_reg};
                mb = ONE_Q16 - t_reg;
            end
            S_BLO_B:
            begin
                ma = {1'b0, death_low_reg};
                mb = t_reg;
            end
            S_BHI_A:
            begin
                ma = {1'b0, birth_high_reg};
                mb = ONE_Q16 - t_reg;
            end
            S_BHI_B:
            begin
                ma = {1'b0, death_high_reg};
                mb = t_reg;
            end
            S_FIN:
            begin
                ma = p_reg;
                mb = ONE_Q16 - q_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        mp        = 34'(ma) * 34'(mb);
        blend_sum = macc_reg + mp;
    end

    slcu_div #(
        .NW (NW),
        .DW (TW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        act_next       = act_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        val_next       = val_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        kcnt_next      = kcnt_reg;
        tot_m_next     = tot_m_reg;
        tot_n_next     = tot_n_reg;
        sum_m_next     = sum_m_reg;
        sum_n_next     = sum_n_reg;
        wm_s_next      = wi;
        wn_s_next      = wn;
        keep_s_next    = 1'b0;
        m_next         = m_reg;
        n_next         = n_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        macc_next      = macc_reg;
        new_value_next = new_value_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        in_ready       = (state_reg == S_IDLE);

        // The second walk stage accumulates whatever the first stage kept.
        if (keep_s_reg)
        begin
            sum_m_next = sum_m_reg + SW'(pm);
            sum_n_next = sum_n_reg + SW'(pn);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    col_next   = col;
                    row_next   = row;
                    c_next     = CXW'(col);
                    r_next     = RXW'(row);
                    val_next   = cell_value;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if ({1'b0, c_reg} >= (CXW + 1)'(GRID_WIDTH))
                    c_next = c_reg - CXW'(GRID_WIDTH);
                else if ({1'b0, r_reg} >= (RXW + 1)'(GRID_HEIGHT))
                    r_next = r_reg - RXW'(GRID_HEIGHT);
                else if (!act_reg)
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    dx_next    = '0;
                    dy_next    = '0;
                    kcnt_next  = '0;
                    tot_m_next = '0;
                    tot_n_next = '0;
                    sum_m_next = '0;
                    sum_n_next = '0;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                keep_s_next = keep_a;
                if (keep_a)
                begin
                    kcnt_next  = kcnt_reg + 1'b1;
                    tot_m_next = tot_m_reg + TW'(wi);
                    tot_n_next = tot_n_reg + TW'(wn);
                end
                if (dy_reg == DCW'(BOX))
                begin
                    dy_next = '0;
                    dx_next = dx_reg + 1'b1;
                    if (dx_reg == DCW'(BOX))
                        state_next = S_DRAIN;
                end
                else
                begin
                    dy_next = dy_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIVM;
            end
            S_DIVM:
            begin
                state_next = S_DIVM_W;
            end
            S_DIVM_W:
            begin
                if (div_done)
                begin
                    m_next     = (tot_m_reg == '0) ? '0 : fill;
                    state_next = S_DIVN;
                end
            end
            S_DIVN:
            begin
                state_next = S_DIVN_W;
            end
            S_DIVN_W:
            begin
                if (div_done)
                begin
                    n_next     = (tot_n_reg == '0) ? '0 : fill;
                    sel_next   = SIG_T;
                    state_next = S_SIG;
                end
            end
            S_SIG:
            begin
                state_next = S_SIG_W;
            end
            S_SIG_W:
            begin
                if (div_done)
                    state_next = S_SIG_MUL;
            end
            S_SIG_MUL:
            begin
                macc_next  = mp;
                state_next = S_SIG_FIN;
            end
            S_SIG_FIN:
            begin
                case (sel_reg)
                    SIG_T:
                    begin
                        t_next     = sig_res;
                        state_next = S_BLO_A;
                    end
                    SIG_P:
                    begin
                        p_next     = sig_res;
                        sel_next   = SIG_Q;
                        state_next = S_SIG;
                    end
                    default:
                    begin
                        q_next     = sig_res;
                        state_next = S_FIN;
                    end
                endcase
            end
            S_BLO_A:
            begin
                macc_next  = mp;
                state_next = S_BLO_B;
            end
            S_BLO_B:
            begin
                lo_next    = blend_sum[31:16];
                state_next = S_BHI_A;
            end
            S_BHI_A:
            begin
                macc_next  = mp;
                state_next = S_BHI_B;
            end
            S_BHI_B:
            begin
                hi_next    = blend_sum[31:16];
                sel_next   = SIG_P;
                state_next = S_SIG;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    new_value_next = mp[32:16];
                    out_col_next   = col_reg;
                    out_row_next   = row_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_reg        <= SIG_T;
            out_valid_reg  <= 1'b0;
            keep_s_reg     <= 1'b0;
            kcnt_reg       <= '0;
            birth_low_reg  <= 16'd18219;
            birth_high_reg <= 16'd23921;
            death_low_reg  <= 16'd17498;
            death_high_reg <= 16'd29164;
            ring_reg       <= 16'd1835;
            inner_reg      <= 16'd9634;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
            keep_s_reg    <= keep_s_next;
            kcnt_reg      <= kcnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BIRTH_LOW:       birth_low_reg  <= cfg_data;
                    CFG_BIRTH_HIGH:      birth_high_reg <= cfg_data;
                    CFG_DEATH_LOW:       death_low_reg  <= cfg_data;
                    CFG_DEATH_HIGH:      death_high_reg <= cfg_data;
                    CFG_RING_STEEPNESS:  ring_reg       <= cfg_data;
                    CFG_INNER_STEEPNESS: inner_reg      <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        c_reg         <= c_next;
        r_reg         <= r_next;
        val_reg       <= val_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        tot_m_reg     <= tot_m_next;
        tot_n_reg     <= tot_n_next;
        sum_m_reg     <= sum_m_next;
        sum_n_reg     <= sum_n_next;
        wm_s_reg      <= wm_s_next;
        wn_s_reg      <= wn_s_next;
        m_reg         <= m_next;
        n_reg         <= n_next;
        t_reg         <= t_next;
        p_reg         <= p_next;
        q_reg         <= q_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        macc_reg      <= macc_next;
        new_value_reg <= new_value_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    // Grid store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            cell_mem[wr_addr] <= wr_data;
        rd_data_reg <= cell_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

    a_kcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kcnt_reg <= KCW'(KERNEL_CAPACITY))
        else $error("kernel entry count passed capacity");

    a_walk_coords: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
            ({1'b0, c_reg} < (CXW + 1)'(GRID_WIDTH)) && ({1'b0, r_reg} < (RXW + 1)'(GRID_HEIGHT)))
        else $error("walk started with unreduced coordinates");

    a_fin_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (p_reg <= ONE_Q16) && (q_reg <= ONE_Q16))
        else $error("logistic result above one");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> !(mem_we && (state_reg == S_WALK)))
        else $error("grid write during kernel walk");

endmodule

`default_nettype wire

// ----- hw/rtl/slcu_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used by smoothlife_cell_update_core.
`default_nettype none

module slcu_div #(
    parameter int NW = 45,
    parameter int DW = 29
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [DW:0]     trial;
    logic            ge;

    // The quotient register starts out holding the numerator and shifts it out at the top.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NW);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- tb/sv/smoothlife_cell_update_core_tb.sv -----
// Self-checking testbench for smoothlife_cell_update_core: fills the grid, then drives
// write and compute words against an in-bench model of the kernel walk and transition.
// Depends on slcu_pkg and the core RTL.
`default_nettype none

module smoothlife_cell_update_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcu_pkg::*;

    localparam int GRID_W  = 256;
    localparam int GRID_H  = 256;
    localparam int R_OUTER = 21;
    localparam int R_INNER = 7;
    localparam int KERNEL_MAX = 4096;
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic [16:0] value;
        logic [7:0]  cx;
        logic [7:0]  cy;
    } cell_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [16:0] cell_value;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] new_value;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    smoothlife_cell_update_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .col        (col),
        .row        (row),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .new_value  (new_value),
        .out_col    (out_col),
        .out_row    (out_row),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Model state: grid copy, register copy and the disk kernel.
    logic [16:0] grid_copy [0:GRID_W*GRID_H-1];
    logic [15:0] reg_copy [0:5];
    int          kern_dx [0:KERNEL_MAX-1];
    int          kern_dy [0:KERNEL_MAX-1];
    longint      kern_wm [0:KERNEL_MAX-1];
    longint      kern_wn [0:KERNEL_MAX-1];
    int          kern_len;
    longint      sum_wm;
    longint      sum_wn;
    logic [15:0] logistic_tab [0:16] = '{
        16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
        16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
        16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
    };

    cell_result_t pending_cells [$];
    int  mismatches;
    int  results_seen;
    int  writes_sent;
    int  computes_sent;
    int  setting_count;
    bit  gaps_on;
    int  burst_left;
    int  hold_request;
    int  hold_left;
    bit  choppy;

    function automatic longint root_floor(input longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd1 << 22;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint ring_weight(input longint rad, input longint d2, input longint rfx);
        if (rad > 0 && 4 * d2 < (2 * rad - 1) * (2 * rad - 1))
            return 65536;
        if (rad >= 0 && 4 * d2 < (2 * rad + 1) * (2 * rad + 1))
            return (2 * rad + 1) * 32768 - rfx;
        return 0;
    endfunction

    task automatic build_disk();
        longint d2;
        longint rfx;
        longint wm;
        longint wa;
        longint wn;
        kern_len = 0;
        sum_wm = 0;
        sum_wn = 0;
        for (int dx = -R_OUTER; dx <= R_OUTER; dx++)
        begin
            for (int dy = -R_OUTER; dy <= R_OUTER; dy++)
            begin
                d2  = dx * dx + dy * dy;
                rfx = root_floor(d2 << 32);
                wm  = ring_weight(R_INNER, d2, rfx);
                wa  = ring_weight(R_OUTER, d2, rfx);
                wn  = (wa > wm) ? wa - wm : 0;
                if ((wm != 0 || wn != 0) && kern_len < KERNEL_MAX)
                begin
                    kern_dx[kern_len] = dx;
                    kern_dy[kern_len] = dy;
                    kern_wm[kern_len] = wm;
                    kern_wn[kern_len] = wn;
                    sum_wm += wm;
                    sum_wn += wn;
                    kern_len++;
                end
            end
        end
    endtask

    function automatic longint logistic_q16(input longint x, input longint a, input longint w);
        longint d;
        longint z;
        longint v;
        longint idx;
        d = (x >= a) ? x - a : a - x;
        if (w == 0)
            w = 1;
        z = (d << 18) / w;
        if (z >= (64'd16 << 15))
            v = logistic_tab[16];
        else
        begin
            idx = z >> 15;
            v = logistic_tab[idx] +
                (((logistic_tab[idx + 1] - logistic_tab[idx]) * (z & 64'h7FFF)) >> 15);
        end
        return (x < a) ? 65536 - v : v;
    endfunction

    function automatic longint mix_bounds(input longint lo_b, input longint hi_b, input longint t);
        return (lo_b * (65536 - t) + hi_b * t) >> 16;
    endfunction

    function automatic logic [16:0] next_cell_value(input int cx, input int cy);
        longint acc_m;
        longint acc_n;
        longint v;
        longint m;
        longint n;
        longint t;
        longint lo;
        longint hi;
        longint p;
        longint q;
        int x;
        int y;
        acc_m = 0;
        acc_n = 0;
        for (int i = 0; i < kern_len; i++)
        begin
            x = (cx + kern_dx[i] + GRID_W) % GRID_W;
            y = (cy + kern_dy[i] + GRID_H) % GRID_H;
            v = grid_copy[y * GRID_W + x];
            acc_m += v * kern_wm[i];
            acc_n += v * kern_wn[i];
        end
        m = (sum_wm != 0) ? acc_m / sum_wm : 0;
        n = (sum_wn != 0) ? acc_n / sum_wn : 0;
        if (m > 65536)
            m = 65536;
        if (n > 65536)
            n = 65536;
        t  = logistic_q16(m, 32768, reg_copy[CFG_INNER_STEEPNESS]);
        lo = mix_bounds(reg_copy[CFG_BIRTH_LOW], reg_copy[CFG_DEATH_LOW], t);
        hi = mix_bounds(reg_copy[CFG_BIRTH_HIGH], reg_copy[CFG_DEATH_HIGH], t);
        p  = logistic_q16(n, lo, reg_copy[CFG_RING_STEEPNESS]);
        q  = logistic_q16(n, hi, reg_copy[CFG_RING_STEEPNESS]);
        return 17'((p * (65536 - q)) >> 16);
    endfunction

    // Offers one word; returns just after the edge that accepts it.
    task automatic send_word(input logic act, input int cx, input int cy, input logic [16:0] val);
        cell_result_t r;
        int gap;
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 12);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        in_valid   = 1'b1;
        action     = act;
        col        = cx[7:0];
        row        = cy[7:0];
        cell_value = val;
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        if (act == ACT_WRITE)
        begin
            grid_copy[cy * GRID_W + cx] = (val > ONE_Q16) ? ONE_Q16 : val;
            writes_sent++;
        end
        else
        begin
            r.value = next_cell_value(cx, cy);
            r.cx = cx[7:0];
            r.cy = cy[7:0];
            pending_cells.push_back(r);
            computes_sent++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cells.size() != 0 || !in_ready)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        reg_copy[idx] = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_setting(input logic [15:0] bl, input logic [15:0] bh, input logic [15:0] dl,
                                input logic [15:0] dh, input logic [15:0] rs, input logic [15:0] is);
        wait_idle();
        write_reg(CFG_BIRTH_LOW, bl);
        write_reg(CFG_BIRTH_HIGH, bh);
        write_reg(CFG_DEATH_LOW, dl);
        write_reg(CFG_DEATH_HIGH, dh);
        write_reg(CFG_RING_STEEPNESS, rs);
        write_reg(CFG_INNER_STEEPNESS, is);
        setting_count++;
    endtask

    // Full grid write so that no kernel walk ever touches an unwritten cell.
    // Tiles of random density give fills spread across the whole range.
    task automatic test_grid_fill();
        int dens [0:255];
        logic [16:0] v;
        for (int i = 0; i < 256; i++)
        begin
            case ($urandom_range(0, 4))
                0: dens[i] = 0;
                1: dens[i] = 100;
                default: dens[i] = $urandom_range(10, 90);
            endcase
        end
        gaps_on = 1'b0;
        for (int y = 0; y < GRID_H; y++)
        begin
            for (int x = 0; x < GRID_W; x++)
            begin
                if ($urandom_range(1, 100) <= dens[(y / 16) * 16 + x / 16])
                    v = ($urandom_range(0, 15) == 0) ? 17'($urandom_range(65536, 131071)) : ONE_Q16;
                else
                    v = ($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 65535)) : 17'd0;
                send_word(ACT_WRITE, x, y, v);
            end
        end
    endtask

    task automatic test_directed();
        gaps_on = 1'b1;
        send_word(ACT_WRITE, 0, 0, 17'h1FFFF);
        send_word(ACT_WRITE, 255, 255, 17'd0);
        send_word(ACT_WRITE, 255, 0, 17'h10001);
        send_word(ACT_WRITE, 0, 255, 17'd1);
        send_word(ACT_WRITE, 128, 128, 17'hFFFF);
        send_word(ACT_COMPUTE, 0, 0, 17'd0);
        send_word(ACT_COMPUTE, 255, 255, 17'h1FFFF);
        send_word(ACT_COMPUTE, 255, 0, 17'd0);
        send_word(ACT_COMPUTE, 0, 255, 17'd0);
        send_word(ACT_COMPUTE, 128, 128, 17'd0);
        send_word(ACT_COMPUTE, 170, 85, 17'd0);
        send_word(ACT_COMPUTE, 85, 170, 17'd0);
    endtask

    task automatic compute_some(input int count);
        for (int i = 0; i < count; i++)
            send_word(ACT_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255), 17'd0);
    endtask

    // Zero steepness must behave as the smallest nonzero steepness.
    task automatic test_settings();
        load_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        compute_some(3);
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        compute_some(3);
        load_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd1);
        compute_some(3);
        for (int k = 0; k < 3; k++)
        begin
            load_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            compute_some(3);
        end
        load_setting(16'd18219, 16'd23921, 16'd17498, 16'd29164, 16'd1835, 16'd9634);
    endtask

    // A held result makes the following compute stall the input side.
    task automatic test_output_stall();
        wait_idle();
        @(posedge clk);
        hold_request = 6000;
        gaps_on = 1'b0;
        compute_some(4);
        gaps_on = 1'b1;
    endtask

    // Writes cluster around a few spots so that later computes see them.
    task automatic test_random_mix();
        int hx [0:3];
        int hy [0:3];
        int h;
        int x;
        int y;
        for (int i = 0; i < 4; i++)
        begin
            hx[i] = $urandom_range(0, 255);
            hy[i] = $urandom_range(0, 255);
        end
        gaps_on = 1'b1;
        for (int i = 0; i < 400; i++)
        begin
            h = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0)
            begin
                x = (hx[h] + $urandom_range(0, 30) + 241) % GRID_W;
                y = (hy[h] + $urandom_range(0, 30) + 241) % GRID_H;
            end
            else
            begin
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
            end
            if ($urandom_range(0, 99) < 25)
                send_word(ACT_COMPUTE, x, y, 17'($urandom_range(0, 131071)));
            else
                send_word(ACT_WRITE, x, y, ($urandom_range(0, 2) == 0) ?
                          17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 1) * 65536));
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                choppy = ~choppy;
            out_ready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d col %0d row %0d",
                             new_value, out_col, out_row);
            end
            else
            begin
                want = pending_cells.pop_front();
                if (new_value !== want.value || out_col !== want.cx || out_row !== want.cy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want value %0d col %0d row %0d, got %0d %0d %0d",
                                 want.value, want.cx, want.cy, new_value, out_col, out_row);
                end
            end
        end
    end

    initial
    begin
        #60000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_WRITE;
        col = '0;
        row = '0;
        cell_value = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        writes_sent = 0;
        computes_sent = 0;
        setting_count = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        hold_request = 0;
        hold_left = 0;
        choppy = 1'b0;
        reg_copy[CFG_BIRTH_LOW]       = 16'd18219;
        reg_copy[CFG_BIRTH_HIGH]      = 16'd23921;
        reg_copy[CFG_DEATH_LOW]       = 16'd17498;
        reg_copy[CFG_DEATH_HIGH]      = 16'd29164;
        reg_copy[CFG_RING_STEEPNESS]  = 16'd1835;
        reg_copy[CFG_INNER_STEEPNESS] = 16'd9634;
        build_disk();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_grid_fill();
        test_directed();
        test_settings();
        test_output_stall();
        test_random_mix();

        wait_idle();
        repeat (100) @(posedge clk);
        $display("Covered %0d cell writes and %0d computes over %0d register settings;",
                 writes_sent, computes_sent, setting_count);
        $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_cells.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
